// ----- hdl/fdst_pkg.sv -----
// Shared types and constants of the fault debounce status table.
package fdst_pkg;

    localparam int INDEX_W = 6;
    localparam int CFG_ADDR_W = 6;

    typedef enum logic [1:0] {
        OP_FAILED = 2'd0,
        OP_PASSED = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_CHECK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_PREFAILED = 3'd0,
        ST_PREPASSED = 3'd1,
        ST_CONFIRMED = 3'd2,
        ST_HEALED    = 3'd3,
        ST_CLEARED   = 3'd4,
        ST_ABSENT    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_CRIT_CONFIRM = 3'd0,
        REG_CONFIRM_LVL  = 3'd1,
        REG_HEALING_ON   = 3'd2,
        REG_HEAL_LVL     = 3'd3,
        REG_AGE          = 3'd4,
        REG_CRIT_SEV     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] fault_index;
        logic [7:0]         severity_in;
        logic [62:0]        time_ns;
    } item_t;

    typedef struct packed {
        logic               new_occurrence;
        logic [2:0]         entry_status;
        logic signed [31:0] counter_now;
        logic [31:0]        occurrences;
        logic [7:0]         peak_severity;
        logic [6:0]         confirmed_count;
    } result_t;

    typedef struct packed {
        logic               critical_confirm_now;
        logic signed [31:0] confirm_level;
        logic               healing_on;
        logic signed [31:0] heal_level;
        logic [62:0]        auto_confirm_age_ns;
        logic [7:0]         critical_severity;
    } cfg_t;

    // one table entry as stored in memory
    typedef struct packed {
        status_t            status;
        logic signed [31:0] count;
        logic [31:0]        occ;
        logic [7:0]         sev;
        logic [62:0]        last_fail;
    } entry_t;

    typedef struct packed {
        logic   write;
        logic   new_occ;
        entry_t entry;
        logic   age_hit;
    } upd_t;

endpackage

// ----- hdl/fault_debounce_status_table.sv -----
// Event: RAM read register, then result register; one item at a time via the entry RAM.
// Time check: if age is nonzero, sweep one entry per cycle on the single RAM port pair.
// A result waits in the output register while the next item is taken.
// Reset sets the config registers to defaults and clears all entry valid bits; RAM contents
// are undefined and only read behind a valid bit.
module fault_debounce_status_table #(
    parameter int FAULT_ENTRIES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  fdst_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output fdst_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    localparam int AW = $clog2(FAULT_ENTRIES > 1 ? FAULT_ENTRIES : 2);
    localparam int EW = $bits(fdst_pkg::entry_t);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_DRAIN = 5'b00100,
        S_POST  = 5'b01000,
        S_RD    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    fdst_pkg::item_t item_reg;
    fdst_pkg::result_t result_reg;
    logic result_valid_reg;
    logic [FAULT_ENTRIES-1:0] valid_reg;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] pend_addr_reg;
    logic pend_reg;
    logic [6:0] confirmed_reg;

    fdst_pkg::cfg_t cfg;
    fdst_pkg::entry_t rd_entry, wr_entry;
    fdst_pkg::upd_t upd;
    logic [EW-1:0] rdata;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [AW-1:0] in_addr, item_addr;
    logic [AW+fdst_pkg::INDEX_W-1:0] in_ext, item_ext;
    logic in_take, item_inside, go, hit, sweep_mode;

    fdst_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    assign in_ext = {{AW{1'b0}}, item.fault_index};
    assign item_ext = {{AW{1'b0}}, item_reg.fault_index};
    assign in_addr = in_ext[AW-1:0];
    assign item_addr = item_ext[AW-1:0];
    assign item_inside = item_ext < (AW + fdst_pkg::INDEX_W)'(FAULT_ENTRIES);

    assign item_stall = (state_reg != S_IDLE);
    assign in_take = item_valid && !item_stall;
    assign go = (state_reg == S_RD) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  raddr = in_addr;
            S_SWEEP: raddr = sweep_reg;
            default: raddr = item_addr;
        endcase
    end

    fdst_ram #(.WIDTH(EW), .DEPTH(FAULT_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wr_entry),
        .raddr(raddr), .rdata(rdata)
    );

    assign rd_entry = fdst_pkg::entry_t'(rdata);
    assign sweep_mode = pend_reg;
    assign hit = sweep_mode ? valid_reg[pend_addr_reg] : (item_inside && valid_reg[item_addr]);

    fdst_update u_upd (
        .cfg(cfg), .operation(item_reg.operation), .severity_in(item_reg.severity_in),
        .time_ns(item_reg.time_ns), .hit(hit), .cur(rd_entry), .upd(upd)
    );

    always_comb
    begin
        we = 1'b0;
        waddr = item_addr;
        wr_entry = upd.entry;
        if (sweep_mode)
        begin
            we = upd.age_hit;
            waddr = pend_addr_reg;
            wr_entry = rd_entry;
            wr_entry.status = fdst_pkg::ST_CONFIRMED;
        end
        else if (go && item_reg.operation != fdst_pkg::OP_CHECK)
        begin
            we = upd.write && item_inside;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (item.operation == fdst_pkg::OP_CHECK &&
                        cfg.auto_confirm_age_ns != 63'd0)
                        state_next = S_SWEEP;
                    else
                        state_next = S_RD;
                end
            end
            S_SWEEP: if (sweep_reg == AW'(FAULT_ENTRIES - 1)) state_next = S_DRAIN;
            S_DRAIN: state_next = S_POST;
            S_POST:  state_next = S_RD;
            S_RD:    if (go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            result_valid_reg <= 1'b0;
            sweep_reg <= '0;
            pend_reg <= 1'b0;
            confirmed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= (state_reg == S_SWEEP);
            if (in_take)
            begin
                sweep_reg <= '0;
                confirmed_reg <= '0;
            end
            else if (state_reg == S_SWEEP)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            if (sweep_mode && upd.age_hit)
            begin
                confirmed_reg <= confirmed_reg + 7'd1;
            end
            if (go && item_inside && item_reg.operation == fdst_pkg::OP_FAILED)
            begin
                valid_reg[item_addr] <= 1'b1;
            end
            if (go)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item;
        end
        pend_addr_reg <= sweep_reg;
        if (go)
        begin
            result_reg.confirmed_count <= confirmed_reg;
            result_reg.new_occurrence <= 1'b0;
            if (item_reg.operation == fdst_pkg::OP_CHECK || !item_inside ||
                (!hit && item_reg.operation != fdst_pkg::OP_FAILED))
            begin
                result_reg.entry_status <= hit ? rd_entry.status : fdst_pkg::ST_ABSENT;
                result_reg.counter_now <= hit ? rd_entry.count : 32'sd0;
                result_reg.occurrences <= hit ? rd_entry.occ : 32'd0;
                result_reg.peak_severity <= hit ? rd_entry.sev : 8'd0;
            end
            else
            begin
                result_reg.new_occurrence <= upd.new_occ;
                result_reg.entry_status <= upd.entry.status;
                result_reg.counter_now <= upd.entry.count;
                result_reg.occurrences <= upd.entry.occ;
                result_reg.peak_severity <= upd.entry.sev;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.entry_status == fdst_pkg::ST_ABSENT |->
        result.counter_now == 32'sd0 && result.occurrences == 32'd0)
        else $error("absent entry with nonzero fields");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !we) else $error("RAM write while idle");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> result_valid) else $error("result lost");

endmodule

// ----- hdl/fdst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rd_reg <= store_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ----- hdl/fdst_cfg.sv -----
// APB configuration registers of the fault table.
module fdst_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    output fdst_pkg::cfg_t                  cfg
);

    fdst_pkg::cfg_t cfg_reg;
    fdst_pkg::reg_index_t sel;
    logic wr;

    assign sel = fdst_pkg::reg_index_t'(paddr[5:3]);
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.critical_confirm_now <= 1'b0;
            cfg_reg.confirm_level        <= -32'sd1;
            cfg_reg.healing_on           <= 1'b0;
            cfg_reg.heal_level           <= 32'sd3;
            cfg_reg.auto_confirm_age_ns  <= 63'd0;
            cfg_reg.critical_severity    <= 8'd3;
        end
        else if (wr)
        begin
            case (sel)
                fdst_pkg::REG_CRIT_CONFIRM: cfg_reg.critical_confirm_now <= pwdata[0];
                fdst_pkg::REG_CONFIRM_LVL:  cfg_reg.confirm_level <= signed'(pwdata[31:0]);
                fdst_pkg::REG_HEALING_ON:   cfg_reg.healing_on <= pwdata[0];
                fdst_pkg::REG_HEAL_LVL:     cfg_reg.heal_level <= signed'(pwdata[31:0]);
                fdst_pkg::REG_AGE:          cfg_reg.auto_confirm_age_ns <= pwdata[62:0];
                fdst_pkg::REG_CRIT_SEV:     cfg_reg.critical_severity <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            fdst_pkg::REG_CRIT_CONFIRM: prdata = {63'd0, cfg_reg.critical_confirm_now};
            fdst_pkg::REG_CONFIRM_LVL:  prdata = {32'd0, cfg_reg.confirm_level};
            fdst_pkg::REG_HEALING_ON:   prdata = {63'd0, cfg_reg.healing_on};
            fdst_pkg::REG_HEAL_LVL:     prdata = {32'd0, cfg_reg.heal_level};
            fdst_pkg::REG_AGE:          prdata = {1'b0, cfg_reg.auto_confirm_age_ns};
            fdst_pkg::REG_CRIT_SEV:     prdata = {56'd0, cfg_reg.critical_severity};
            default:                    prdata = 64'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/fdst_update.sv -----
// Next-entry logic: failed, passed and clear updates, and the age test.
module fdst_update (
    input  fdst_pkg::cfg_t  cfg,
    input  logic [1:0]      operation,
    input  logic [7:0]      severity_in,
    input  logic [62:0]     time_ns,
    input  logic            hit,
    input  fdst_pkg::entry_t cur,
    output fdst_pkg::upd_t  upd
);

    logic               crit;
    logic               cleared;
    logic signed [31:0] c;
    logic signed [31:0] cp;
    logic [63:0]        due;

    assign crit = cfg.critical_confirm_now && (severity_in == cfg.critical_severity);
    assign cleared = (cur.status == fdst_pkg::ST_CLEARED);
    assign due = {1'b0, cur.last_fail} + {1'b0, cfg.auto_confirm_age_ns};

    always_comb
    begin
        c = cleared ? 32'sd0 : cur.count;
        if (c != 32'sh8000_0000)
        begin
            c = c - 32'sd1;
        end
        cp = cur.count;
        if (cp != 32'sh7FFF_FFFF)
        begin
            cp = cp + 32'sd1;
        end

        upd.write = 1'b0;
        upd.new_occ = 1'b0;
        upd.entry = cur;
        upd.age_hit = hit && (cur.status == fdst_pkg::ST_PREFAILED) &&
                      (cur.last_fail != 63'd0) && (due <= {1'b0, time_ns});

        case (fdst_pkg::op_t'(operation))
            fdst_pkg::OP_FAILED:
            begin
                upd.write = 1'b1;
                upd.entry.last_fail = time_ns;
                if (!hit)
                begin
                    upd.new_occ = 1'b1;
                    upd.entry.count = -32'sd1;
                    upd.entry.status = (crit || cfg.confirm_level >= -32'sd1) ?
                                       fdst_pkg::ST_CONFIRMED : fdst_pkg::ST_PREFAILED;
                    upd.entry.occ = 32'd1;
                    upd.entry.sev = severity_in;
                end
                else
                begin
                    upd.new_occ = cleared;
                    if (severity_in > cur.sev)
                    begin
                        upd.entry.sev = severity_in;
                    end
                    if (cur.occ != 32'hFFFF_FFFF)
                    begin
                        upd.entry.occ = cur.occ + 32'd1;
                    end
                    upd.entry.count = c;
                    if (crit || c <= cfg.confirm_level)
                        upd.entry.status = fdst_pkg::ST_CONFIRMED;
                    else if (c < 0)
                        upd.entry.status = fdst_pkg::ST_PREFAILED;
                    else if (c > 0)
                        upd.entry.status = fdst_pkg::ST_PREPASSED;
                    else if (cleared)
                        upd.entry.status = fdst_pkg::ST_CLEARED;
                end
            end
            fdst_pkg::OP_PASSED:
            begin
                if (hit && !cleared)
                begin
                    upd.write = 1'b1;
                    upd.entry.count = cp;
                    if (cfg.healing_on && cp >= cfg.heal_level)
                        upd.entry.status = fdst_pkg::ST_HEALED;
                    else if (cp > 0)
                        upd.entry.status = fdst_pkg::ST_PREPASSED;
                    else if (cp < 0)
                        upd.entry.status = fdst_pkg::ST_PREFAILED;
                end
            end
            fdst_pkg::OP_CLEAR:
            begin
                if (hit)
                begin
                    upd.write = 1'b1;
                    upd.new_occ = 1'b1;
                    upd.entry.status = fdst_pkg::ST_CLEARED;
                end
            end
            default: ;
        endcase
    end

endmodule
